@@ hdl/rau_pkg.sv @@
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies

package rau_pkg;

  localparam int OpW  = 16;
  localparam int ResW = 48;
  localparam int MagW = OpW + 1;
  localparam int QDepth = 2;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_SCL = 3'd4;
  localparam logic [2:0] ACT_SMP = 3'd5;
  localparam logic [2:0] ACT_NEG = 3'd6;
  localparam logic [2:0] ACT_SQR = 3'd7;

  typedef struct packed {
    logic [2:0]            action;
    logic signed [OpW-1:0] an;
    logic signed [OpW-1:0] ad;
    logic signed [OpW-1:0] bn;
    logic signed [OpW-1:0] bd;
    logic                  need_gcd;
    logic                  zero_div;
  } rau_cmd_t;

  typedef struct packed {
    logic [ResW-1:0] res_num;
    logic [ResW-1:0] res_den;
    logic            div_error;
  } rau_res_t;

endpackage

@@ hdl/rau_front.sv @@
// rau_front: accepts requests, fixes zero denominators, classifies the action
// and buffers commands in a short queue; depends on rau_pkg

module rau_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        action,
  input  logic [15:0]       a_num,
  input  logic [15:0]       a_den,
  input  logic [15:0]       b_num,
  input  logic [15:0]       b_den,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output rau_pkg::rau_cmd_t cmd
);
  import rau_pkg::*;

  rau_cmd_t  q_r [QDepth];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  rau_cmd_t  c;
  logic      push, pop;

  always_comb begin
    c.action = action;
    c.an = a_num;
    c.ad = (a_den == '0) ? OpW'(1) : a_den;
    c.bn = b_num;
    c.bd = (b_den == '0) ? OpW'(1) : b_den;
    c.need_gcd = (action == ACT_ADD) || (action == ACT_SUB) || (action == ACT_SMP);
    c.zero_div = (action == ACT_DIV) && (b_num == '0);
  end

  assign in_ready  = (cnt_r != 2'(QDepth));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];
  assign wp_nxt    = push ? ~wp_r : wp_r;
  assign rp_nxt    = pop ? ~rp_r : rp_r;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) q_r[wp_r] <= c;
  end
endmodule

@@ hdl/rau_back.sv @@
// rau_back: sequencer with an iterative gcd, a radix-2 divider and one shared
// multiplier; holds the result in an output register; depends on rau_pkg

module rau_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  rau_pkg::rau_cmd_t cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output rau_pkg::rau_res_t res
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_M1   = 3'd3;
  localparam logic [2:0] S_M2   = 3'd4;
  localparam logic [2:0] S_M3   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam int CntW = $clog2(MagW + 1);

  logic [2:0]            st_r, st_nxt;
  rau_cmd_t              c_r;
  logic [MagW-1:0]       gx_r, gy_r;
  logic [MagW-1:0]       dq_r, drem_r, dd_r;
  logic [CntW-1:0]       cnt_r;
  logic                  dsel_r;
  logic signed [MagW-1:0] q0_r, q1_r;
  logic [ResW-1:0]       rn_r, rd_r, t_r;
  logic                  rv_r, rv_nxt;
  rau_res_t              res_r;

  // shared signed multiplier
  logic signed [MagW-1:0] ma, mb;
  logic signed [2*MagW-1:0] mp;
  assign mp = ma * mb;

  function automatic logic [MagW-1:0] absv(input logic signed [OpW-1:0] v);
    logic signed [MagW-1:0] e;
    e = MagW'(v);
    return (e < 0) ? MagW'(-e) : e;
  endfunction

  logic [MagW:0] rem_sh;
  logic          rem_ge;
  assign rem_sh = {drem_r, dq_r[MagW-1]};
  assign rem_ge = rem_sh >= {1'b0, dd_r};

  logic signed [OpW-1:0] dnum;
  logic signed [MagW-1:0] qs;
  assign dnum = dsel_r ? ((c_r.action == ACT_SMP) ? c_r.ad : c_r.bd)
                       : ((c_r.action == ACT_SMP) ? c_r.an : c_r.ad);
  assign qs = dnum[OpW-1] ? -$signed(dq_r) : $signed(dq_r);

  logic [ResW-1:0] fin_rd;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      S_M1: begin
        unique case (c_r.action) inside
          ACT_ADD, ACT_SUB: begin ma = q0_r; mb = MagW'(c_r.an); end
          ACT_MUL: begin ma = MagW'(c_r.an); mb = MagW'(c_r.bn); end
          ACT_DIV: begin ma = MagW'(c_r.an); mb = MagW'(c_r.bd); end
          ACT_SCL: begin ma = MagW'(c_r.bn); mb = MagW'(c_r.an); end
          default: begin ma = MagW'(c_r.an); mb = MagW'(c_r.an); end
        endcase
      end
      S_M2: begin
        unique case (c_r.action) inside
          ACT_ADD, ACT_SUB: begin ma = q1_r; mb = MagW'(c_r.bn); end
          ACT_MUL: begin ma = MagW'(c_r.ad); mb = MagW'(c_r.bd); end
          ACT_DIV: begin ma = MagW'(c_r.ad); mb = MagW'(c_r.bn); end
          default: begin ma = MagW'(c_r.ad); mb = MagW'(c_r.ad); end
        endcase
      end
      S_M3: begin ma = q1_r; mb = MagW'(c_r.bd); end
      default: ;
    endcase
  end

  assign cmd_ready = (st_r == S_IDLE);
  assign fin_rd = (rd_r == '0) ? ResW'(1) : rd_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (cmd_valid) begin
        if (cmd.zero_div || cmd.action == ACT_NEG || cmd.action == ACT_SCL)
          st_nxt = (cmd.action == ACT_SCL) ? S_M1 : S_OUT;
        else if (cmd.need_gcd) st_nxt = S_GCD;
        else st_nxt = S_M1;
      end
      S_GCD:  if (gy_r == '0) st_nxt = S_DIV;
      S_DIV:  if (cnt_r == CntW'(MagW) && dsel_r) begin
        st_nxt = (c_r.action == ACT_SMP) ? S_OUT : S_M1;
      end
      S_M1:   st_nxt = (c_r.action == ACT_SCL) ? S_OUT : S_M2;
      S_M2:   st_nxt = (c_r.action == ACT_ADD || c_r.action == ACT_SUB) ? S_M3 : S_OUT;
      S_M3:   st_nxt = S_OUT;
      S_OUT:  if (!rv_r || res_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rv_nxt = rv_r;
    if (rv_r && res_ready) rv_nxt = 1'b0;
    if (st_r == S_OUT && (!rv_r || res_ready)) rv_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      rv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rv_r <= rv_nxt;
    end
    unique case (st_r)
      S_IDLE: if (cmd_valid) begin
        c_r <= cmd;
        dsel_r <= 1'b0;
        rn_r <= (cmd.action == ACT_NEG) ? -ResW'(cmd.an) : '0;
        rd_r <= (cmd.action == ACT_NEG || cmd.action == ACT_SCL) ? ResW'(cmd.ad)
                                                                 : ResW'(1);
        if (cmd.action == ACT_SMP) begin
          gx_r <= absv(cmd.an);
          gy_r <= absv(cmd.ad);
        end else begin
          gx_r <= absv(cmd.ad);
          gy_r <= absv(cmd.bd);
        end
      end
      S_GCD: begin
        if (gy_r == '0) begin
          dsel_r <= 1'b0;
          cnt_r <= '0;
          dq_r <= absv(dnum);
          drem_r <= '0;
          dd_r <= gx_r;
        end else if (gx_r >= gy_r) begin
          gx_r <= gx_r - gy_r;
        end else begin
          gx_r <= gy_r;
          gy_r <= gx_r;
        end
      end
      S_DIV: begin
        if (cnt_r == CntW'(MagW)) begin
          if (!dsel_r) begin
            q0_r <= qs;
            dsel_r <= 1'b1;
            cnt_r <= '0;
            drem_r <= '0;
            dq_r <= (c_r.action == ACT_SMP) ? absv(c_r.ad) : absv(c_r.bd);
          end else if (c_r.action == ACT_SMP) begin
            rn_r <= ResW'(q0_r);
            rd_r <= ResW'(qs);
          end else begin
            // factor for a is bd/g, for b is ad/g
            q0_r <= qs;
            q1_r <= q0_r;
          end
        end else begin
          cnt_r <= cnt_r + CntW'(1);
          drem_r <= rem_ge ? MagW'(rem_sh - {1'b0, dd_r}) : rem_sh[MagW-1:0];
          dq_r <= {dq_r[MagW-2:0], rem_ge};
        end
      end
      S_M1: begin
        if (c_r.action == ACT_SCL) rn_r <= ResW'(mp);
        else t_r <= ResW'(mp);
      end
      S_M2: begin
        if (c_r.action == ACT_ADD) rn_r <= t_r + ResW'(mp);
        else if (c_r.action == ACT_SUB) rn_r <= t_r - ResW'(mp);
        else begin
          rn_r <= t_r;
          rd_r <= ResW'(mp);
        end
      end
      S_M3: rd_r <= ResW'(mp);
      S_OUT: if (!rv_r || res_ready) begin
        res_r.res_num <= rn_r;
        res_r.res_den <= fin_rd;
        res_r.div_error <= c_r.zero_div;
      end
      default: ;
    endcase
  end

  assign res_valid = rv_r;
  assign res = res_r;
endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// rational_arithmetic_unit: top level, front queue and back sequencer
// depends on rau_pkg, rau_front, rau_back
//
// One request gives one result. Sum, difference and simplify run a
// subtractive gcd on 17-bit magnitudes, one step per cycle, then two
// shift-subtract divisions and, for sum and difference, the multiplier
// states M1 to M3. Multiply, divide and square use the multiplier states
// M1 and M2, scale uses M1 only, and negate and zero divisor go straight
// to the output state. A two-entry queue lets new requests be taken while
// the back end works and the result register waits to be read.

module rational_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // action
  input  logic [63:0] in_tdata,   // a_num, a_den, b_num, b_den
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // res_num, res_den
  output logic [2:0]  out_tuser   // is_zero, is_negative, div_error
);
  import rau_pkg::*;

  logic     cmd_valid, cmd_ready;
  rau_cmd_t cmd;
  rau_res_t res;

  rau_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .action(in_tuser),
    .a_num(in_tdata[15:0]), .a_den(in_tdata[31:16]),
    .b_num(in_tdata[47:32]), .b_den(in_tdata[63:48]),
    .cmd_valid, .cmd_ready, .cmd
  );

  rau_back u_back (
    .clk, .rst_n,
    .cmd_valid, .cmd_ready, .cmd,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {res.res_den, res.res_num};
  assign out_tuser = {res.div_error, res.res_num[ResW-1], res.res_num == '0};

  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:48] != '0) else $error("zero denominator");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata[47:0] == '0) else $error("error result not zero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("result dropped");
endmodule
